// ===== rtl/core/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

    localparam int DATA_W = 32;
    localparam int OPER_W = 16;
    localparam int MAG_W  = OPER_W + 1;
    localparam int NUM_W  = 33;
    localparam int PC_W   = 5;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;
    localparam logic [1:0] REQ_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [OPER_W-1:0] a_num;
        logic signed [OPER_W-1:0] a_den;
        logic signed [OPER_W-1:0] b_num;
        logic signed [OPER_W-1:0] b_den;
    } in_beat_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]  res_num;
        logic signed [DATA_W-1:0] res_den;
        logic                     error;
    } out_beat_t;

    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_GCD   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_T1    = 4'd4,
        CMD_T2    = 4'd5,
        CMD_LDEN  = 4'd6,
        CMD_EQ    = 4'd7,
        CMD_MNUM  = 4'd8,
        CMD_MDEN  = 4'd9,
        CMD_DNUM  = 4'd10,
        CMD_DDEN  = 4'd11,
        CMD_CHECK = 4'd12,
        CMD_FINAL = 4'd13,
        CMD_ERR   = 4'd14
    } cmd_t;

    typedef enum logic [2:0] {
        SRC_AN  = 3'd0,
        SRC_AD  = 3'd1,
        SRC_BN  = 3'd2,
        SRC_BD  = 3'd3,
        SRC_NUM = 3'd4,
        SRC_DEN = 3'd5
    } src_t;

    typedef enum logic [1:0] {
        DST_U = 2'd0,
        DST_V = 2'd1,
        DST_W = 2'd2,
        DST_X = 2'd3
    } dst_t;

    typedef struct packed {
        cmd_t cmd;
        src_t src_a;
        src_t src_b;
        dst_t dst;
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t op;
        logic    to_reduce;
    } step_t;

    typedef struct packed {
        logic       gcd_done;
        logic       div_done;
        logic       in_err;
        logic       den_zero;
        logic       dens_equal;
        logic       out_free;
        logic [1:0] req_type;
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_ADD    = 5'd0;
    localparam logic [PC_W-1:0] PC_EQ     = 5'd6;
    localparam logic [PC_W-1:0] PC_MUL    = 5'd7;
    localparam logic [PC_W-1:0] PC_DIV    = 5'd15;
    localparam logic [PC_W-1:0] PC_REDUCE = 5'd17;
    localparam logic [PC_W-1:0] PC_ERR    = 5'd22;

    function automatic step_t mk_step(cmd_t c, src_t a, src_t b, dst_t d, logic r);
        step_t s;
        s.op.cmd   = c;
        s.op.src_a = a;
        s.op.src_b = b;
        s.op.dst   = d;
        s.to_reduce = r;
        return s;
    endfunction

    // Sequence of datapath steps for each operation, all ending in the common reduction.
    function automatic step_t ustep(logic [PC_W-1:0] pc);
        step_t s;
        case (pc)
            5'd0:    s = mk_step(CMD_GCD,   SRC_AD,  SRC_BD,  DST_U, 1'b0);
            5'd1:    s = mk_step(CMD_DIV,   SRC_BD,  SRC_BD,  DST_U, 1'b0);
            5'd2:    s = mk_step(CMD_DIV,   SRC_AD,  SRC_AD,  DST_V, 1'b0);
            5'd3:    s = mk_step(CMD_T1,    SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd4:    s = mk_step(CMD_T2,    SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd5:    s = mk_step(CMD_LDEN,  SRC_AN,  SRC_AN,  DST_U, 1'b1);
            5'd6:    s = mk_step(CMD_EQ,    SRC_AN,  SRC_AN,  DST_U, 1'b1);
            5'd7:    s = mk_step(CMD_GCD,   SRC_AN,  SRC_BD,  DST_U, 1'b0);
            5'd8:    s = mk_step(CMD_DIV,   SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd9:    s = mk_step(CMD_DIV,   SRC_BD,  SRC_BD,  DST_V, 1'b0);
            5'd10:   s = mk_step(CMD_GCD,   SRC_BN,  SRC_AD,  DST_U, 1'b0);
            5'd11:   s = mk_step(CMD_DIV,   SRC_BN,  SRC_BN,  DST_W, 1'b0);
            5'd12:   s = mk_step(CMD_DIV,   SRC_AD,  SRC_AD,  DST_X, 1'b0);
            5'd13:   s = mk_step(CMD_MNUM,  SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd14:   s = mk_step(CMD_MDEN,  SRC_AN,  SRC_AN,  DST_U, 1'b1);
            5'd15:   s = mk_step(CMD_DNUM,  SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd16:   s = mk_step(CMD_DDEN,  SRC_AN,  SRC_AN,  DST_U, 1'b1);
            5'd17:   s = mk_step(CMD_CHECK, SRC_AN,  SRC_AN,  DST_U, 1'b0);
            5'd18:   s = mk_step(CMD_GCD,   SRC_NUM, SRC_DEN, DST_U, 1'b0);
            5'd19:   s = mk_step(CMD_DIV,   SRC_NUM, SRC_NUM, DST_U, 1'b0);
            5'd20:   s = mk_step(CMD_DIV,   SRC_DEN, SRC_DEN, DST_V, 1'b0);
            5'd21:   s = mk_step(CMD_FINAL, SRC_AN,  SRC_AN,  DST_U, 1'b0);
            default: s = mk_step(CMD_ERR,   SRC_AN,  SRC_AN,  DST_U, 1'b0);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rau_gcd.sv =====
`default_nettype none

// Binary gcd: one shift or subtract per cycle.
module rau_gcd
    import rau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output logic                   done,
    output logic [DATA_W-1:0]      result
);

    localparam int K_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [DATA_W-1:0] res_reg, res_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        p_next    = p_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            p_next    = a;
            q_next    = b;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (p_reg == '0)
            begin
                res_next  = q_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (q_reg == '0)
            begin
                res_next  = p_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!p_reg[0] && !q_reg[0])
            begin
                p_next = p_reg >> 1;
                q_next = q_reg >> 1;
                k_next = K_W'(k_reg + 1'b1);
            end
            else if (!p_reg[0])
            begin
                p_next = p_reg >> 1;
            end
            else if (!q_reg[0])
            begin
                q_next = q_reg >> 1;
            end
            else if (p_reg >= q_reg)
            begin
                p_next = (p_reg - q_reg) >> 1;
            end
            else
            begin
                q_next = (q_reg - p_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        q_reg   <= q_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rau_div
    import rau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_datapath.sv =====
`default_nettype none

module rau_datapath
    import rau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    input  wire in_beat_t   in_data,
    input  wire logic       out_stall,
    output dp_status_t      status,
    output logic            out_valid,
    output out_beat_t       out_data
);

    logic signed [OPER_W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]               req_reg;
    logic [DATA_W-1:0]        g_reg, u_reg, v_reg, w_reg, x_reg;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [NUM_W-1:0]  den_reg, den_next;
    dst_t                     dst_reg;
    out_beat_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [MAG_W-1:0]         mag_an, mag_ad, mag_bn, mag_bd;
    logic [DATA_W-1:0]        mag_num, mag_den;
    logic [DATA_W-1:0]        opa, opb;
    logic                     gcd_done, div_done;
    logic [DATA_W-1:0]        gcd_res, div_res;
    logic signed [MAG_W:0]    mul_x, mul_y;
    logic signed [2*MAG_W+1:0] prod;
    logic signed [2*MAG_W+1:0] term;
    logic                     neg;
    logic                     out_free;

    function automatic logic [MAG_W-1:0] mag16(logic signed [OPER_W-1:0] v);
        logic [MAG_W-1:0] e;
        e = {v[OPER_W-1], v};
        return v[OPER_W-1] ? MAG_W'(0) - e : e;
    endfunction

    function automatic logic [DATA_W-1:0] mag33(logic signed [NUM_W-1:0] v);
        logic [NUM_W-1:0] m;
        m = v[NUM_W-1] ? NUM_W'(0) - v : v;
        return m[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick(src_t s, logic [MAG_W-1:0] an, logic [MAG_W-1:0] ad,
                                               logic [MAG_W-1:0] bn, logic [MAG_W-1:0] bd,
                                               logic [DATA_W-1:0] n, logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        case (s)
            SRC_AN:  r = DATA_W'(an);
            SRC_AD:  r = DATA_W'(ad);
            SRC_BN:  r = DATA_W'(bn);
            SRC_BD:  r = DATA_W'(bd);
            SRC_NUM: r = n;
            SRC_DEN: r = d;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign mag_an  = mag16(an_reg);
    assign mag_ad  = mag16(ad_reg);
    assign mag_bn  = mag16(bn_reg);
    assign mag_bd  = mag16(bd_reg);
    assign mag_num = mag33(num_reg);
    assign mag_den = mag33(den_reg);
    assign opa = pick(cmd.src_a, mag_an, mag_ad, mag_bn, mag_bd, mag_num, mag_den);
    assign opb = pick(cmd.src_b, mag_an, mag_ad, mag_bn, mag_bd, mag_num, mag_den);

    rau_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.cmd == CMD_GCD),
        .a      (opa),
        .b      (opb),
        .done   (gcd_done),
        .result (gcd_res)
    );

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.cmd == CMD_DIV),
        .dividend (opa),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (div_res)
    );

    // One shared multiplier; operands chosen by the current step.
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        neg   = 1'b0;
        case (cmd.cmd)
            CMD_T1:
            begin
                mul_x = (MAG_W+1)'(an_reg);
                mul_y = {1'b0, u_reg[MAG_W-1:0]};
                neg   = ad_reg[OPER_W-1];
            end
            CMD_T2:
            begin
                mul_x = (MAG_W+1)'(bn_reg);
                mul_y = {1'b0, v_reg[MAG_W-1:0]};
                neg   = bd_reg[OPER_W-1] ^ (req_reg == REQ_SUB);
            end
            CMD_LDEN:
            begin
                mul_x = {1'b0, mag_bd};
                mul_y = {1'b0, v_reg[MAG_W-1:0]};
            end
            CMD_MNUM:
            begin
                mul_x = {1'b0, u_reg[MAG_W-1:0]};
                mul_y = {1'b0, w_reg[MAG_W-1:0]};
                neg   = an_reg[OPER_W-1] ^ bn_reg[OPER_W-1];
            end
            CMD_MDEN:
            begin
                mul_x = {1'b0, x_reg[MAG_W-1:0]};
                mul_y = {1'b0, v_reg[MAG_W-1:0]};
                neg   = ad_reg[OPER_W-1] ^ bd_reg[OPER_W-1];
            end
            CMD_DNUM:
            begin
                mul_x = (MAG_W+1)'(an_reg);
                mul_y = (MAG_W+1)'(bd_reg);
            end
            CMD_DDEN:
            begin
                mul_x = (MAG_W+1)'(ad_reg);
                mul_y = (MAG_W+1)'(bn_reg);
            end
            default:
            begin
                neg = 1'b0;
            end
        endcase
    end

    assign prod     = mul_x * mul_y;
    assign term     = neg ? -prod : prod;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (cmd.cmd)
            CMD_T1, CMD_MNUM, CMD_DNUM:
            begin
                num_next = term[NUM_W-1:0];
            end
            CMD_T2:
            begin
                num_next = num_reg + term[NUM_W-1:0];
            end
            CMD_LDEN, CMD_MDEN, CMD_DDEN:
            begin
                den_next = term[NUM_W-1:0];
            end
            CMD_EQ:
            begin
                if (req_reg == REQ_SUB)
                begin
                    num_next = NUM_W'(an_reg) - NUM_W'(bn_reg);
                end
                else
                begin
                    num_next = NUM_W'(an_reg) + NUM_W'(bn_reg);
                end
                den_next = NUM_W'(ad_reg);
            end
            CMD_FINAL:
            begin
                out_next.res_num = num_reg[NUM_W-1] ? NUM_W'(0) - {1'b0, u_reg}
                                                    : {1'b0, u_reg};
                out_next.res_den = den_reg[NUM_W-1] ? DATA_W'(0) - v_reg : v_reg;
                out_next.error   = 1'b0;
                out_valid_next   = 1'b1;
            end
            CMD_ERR:
            begin
                out_next.res_num = '0;
                out_next.res_den = '0;
                out_next.error   = 1'b1;
                out_valid_next   = 1'b1;
            end
            default:
            begin
                num_next = num_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        out_reg <= out_next;
        if (cmd.cmd == CMD_LOAD)
        begin
            req_reg <= in_data.req_type;
            an_reg  <= in_data.a_num;
            ad_reg  <= in_data.a_den;
            bn_reg  <= in_data.b_num;
            bd_reg  <= in_data.b_den;
        end
        if (cmd.cmd == CMD_DIV)
        begin
            dst_reg <= cmd.dst;
        end
        if (gcd_done)
        begin
            g_reg <= gcd_res;
        end
        if (div_done)
        begin
            case (dst_reg)
                DST_U:   u_reg <= div_res;
                DST_V:   v_reg <= div_res;
                DST_W:   w_reg <= div_res;
                default: x_reg <= div_res;
            endcase
        end
    end

    assign status.gcd_done   = gcd_done;
    assign status.div_done   = div_done;
    assign status.in_err     = (ad_reg == '0) || (bd_reg == '0);
    assign status.den_zero   = (den_reg == '0);
    assign status.dens_equal = (ad_reg == bd_reg);
    assign status.out_free   = out_free;
    assign status.req_type   = req_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rau_ctrl.sv =====
`default_nettype none

// Sequencer: steps through the operation's program, waiting on the gcd and divider.
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire dp_status_t status,
    output logic            in_stall,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DISP = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    step_t            step;
    dp_cmd_t          idle_cmd;

    assign step = ustep(pc_reg);

    always_comb
    begin
        idle_cmd       = step.op;
        idle_cmd.cmd   = CMD_NONE;
        state_next     = state_reg;
        pc_next        = pc_reg;
        cmd            = idle_cmd;
        in_stall       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.cmd    = CMD_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = ST_RUN;
                if (status.in_err)
                begin
                    pc_next = PC_ERR;
                end
                else
                begin
                    case (status.req_type)
                        REQ_ADD, REQ_SUB: pc_next = status.dens_equal ? PC_EQ : PC_ADD;
                        REQ_MUL:          pc_next = PC_MUL;
                        default:          pc_next = PC_DIV;
                    endcase
                end
            end
            ST_RUN:
            begin
                case (step.op.cmd)
                    CMD_GCD, CMD_DIV:
                    begin
                        cmd        = step.op;
                        state_next = ST_WAIT;
                    end
                    CMD_CHECK:
                    begin
                        pc_next = status.den_zero ? PC_ERR : PC_W'(pc_reg + 1'b1);
                    end
                    CMD_FINAL, CMD_ERR:
                    begin
                        if (status.out_free)
                        begin
                            cmd        = step.op;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd     = step.op;
                        pc_next = step.to_reduce ? PC_REDUCE : PC_W'(pc_reg + 1'b1);
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (status.gcd_done || status.div_done)
                begin
                    pc_next    = PC_W'(pc_reg + 1'b1);
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rational_arith_unit.sv =====
`default_nettype none

// Channel   Direction  Beat type    Handshake
// in        input      in_beat_t    in_valid / in_stall
// out       output     out_beat_t   out_valid / out_stall
//
// One beat in gives one beat out. A zero input denominator goes straight to the
// error step without any gcd or division. Each binary gcd runs one shift or
// subtract per cycle, and each exact division by a gcd holds the sequencer
// while the bit-serial divider runs. Multiply runs two gcds and four divisions
// before the reduction, add and subtract one gcd and two divisions (none when
// the denominators are equal), divide none.
// Reset clears the sequencer and the output valid flag. A stalled result holds
// in the output register while the next item is already being worked on.

module rational_arith_unit
    import rau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_beat_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_beat_t     out_data
);

    // The controller sequences the steps; the datapath holds the operands,
    // the multiplier, the gcd unit and the divider.
    dp_cmd_t    cmd;
    dp_status_t status;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    rau_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== dv/rational_arith_unit_test.sv =====
module rational_arith_unit_test;
    import rau_pkg::*;

    // The bound covers the slowest item. Each result may also sit out a long
    // run of receiver stalls, so the bound is taken several times over.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_MAX = 10;
    localparam int RANDOM_ITEMS = 430;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    rational_arith_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Results still owed by the block, oldest first.
    out_beat_t pending_fractions[$];
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    // One row of the directed part. Where known is set, the row carries its own
    // answer; otherwise the answer comes from the fraction predictor.
    typedef struct {
        logic [1:0]  op;
        int          an;
        int          ad;
        int          bn;
        int          bd;
        bit          known;
        longint      rn;
        longint      rd;
        bit          rerr;
    } directed_row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint gcd_mag(longint p, longint q);
        longint r;
        if (p < 0) p = -p;
        if (q < 0) q = -q;
        while (q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    // Works out the reduced fraction for one request beat. Quotients truncate
    // towards zero, and signs stay wherever the arithmetic leaves them.
    function automatic out_beat_t reduce_fraction(in_beat_t b);
        longint    an;
        longint    ad;
        longint    bn;
        longint    bd;
        longint    num;
        longint    den;
        longint    lcm;
        longint    g1;
        longint    g2;
        longint    g;
        out_beat_t r;
        an = longint'($signed(b.a_num));
        ad = longint'($signed(b.a_den));
        bn = longint'($signed(b.b_num));
        bd = longint'($signed(b.b_den));
        r = '0;
        if (ad == 0 || bd == 0)
        begin
            r.error = 1'b1;
            return r;
        end
        case (b.req_type)
            REQ_ADD, REQ_SUB:
            begin
                if (ad != bd)
                begin
                    lcm = ((ad < 0 ? -ad : ad) / gcd_mag(ad, bd)) * (bd < 0 ? -bd : bd);
                    num = (b.req_type == REQ_ADD) ? an * (lcm / ad) + bn * (lcm / bd)
                                                  : an * (lcm / ad) - bn * (lcm / bd);
                    den = lcm;
                end
                else
                begin
                    num = (b.req_type == REQ_ADD) ? an + bn : an - bn;
                    den = ad;
                end
            end
            REQ_MUL:
            begin
                g1 = gcd_mag(an, bd);
                g2 = gcd_mag(bn, ad);
                num = (an / g1) * (bn / g2);
                den = (ad / g2) * (bd / g1);
            end
            default:
            begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        // A divide by a zero fraction leaves a zero denominator.
        if (den == 0)
        begin
            r.error = 1'b1;
            return r;
        end
        g = gcd_mag(num, den);
        num = num / g;
        den = den / g;
        r.res_num = num[NUM_W-1:0];
        r.res_den = den[DATA_W-1:0];
        return r;
    endfunction

    // Presents one beat, idling beforehand as the current phase asks, and holds it
    // unchanged until the block takes it. Every change happens on a falling edge.
    task automatic offer_request(in_beat_t b, bit known, out_beat_t answer);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= in_beat_t'({$urandom, $urandom, $urandom});
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_fractions.push_back(known ? answer : reduce_fraction(b));
    endtask

    function automatic logic [15:0] pick_operand(bit is_den);
        case ($urandom_range(9))
            0:       return is_den ? 16'sd1 : 16'sd0;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'hFFFF;
            4, 5:    return 16'($signed($urandom_range(24)) - 12);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed fractions with random content; now and then a zero
    // denominator, and often the same denominator on both sides so that the
    // shortcut in add and subtract gets its share.
    function automatic in_beat_t random_request();
        in_beat_t b;
        b.req_type = 2'($urandom);
        b.a_num    = pick_operand(1'b0);
        b.b_num    = pick_operand(1'b0);
        b.a_den    = ($urandom_range(19) == 0) ? 16'sd0 : pick_operand(1'b1);
        b.b_den    = ($urandom_range(19) == 0) ? 16'sd0 : pick_operand(1'b1);
        if ($urandom_range(5) == 0)
        begin
            b.b_den = b.a_den;
        end
        return b;
    endfunction

    // The receiving side stalls at random, drawn afresh on every falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker: each beat taken from the block is matched against the
    // oldest outstanding expectation, field by field.
    always @(posedge clk)
    begin
        out_beat_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fractions.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("unexpected result beat: num %0d den %0d error %0b",
                             out_data.res_num, out_data.res_den, out_data.error);
                end
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (out_data.res_num !== want.res_num || out_data.res_den !== want.res_den
                    || out_data.error !== want.error)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("result mismatch: expected %0d/%0d error %0b, got %0d/%0d error %0b",
                                 want.res_num, want.res_den, want.error,
                                 out_data.res_num, out_data.res_den, out_data.error);
                    end
                end
            end
        end
    end

    // A hung block must not hold the run forever.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rational_arith_unit_test failed");
            $finish;
        end
    end

    initial
    begin
        directed_row_t rows[$];
        in_beat_t      b;
        out_beat_t     answer;
        int            phase;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 33;
        recv_stall_pct = 83;

        // Directed rows: the extremes of every field, each operation, the zero
        // denominator on either side, a divide by zero and zero numerators.
        rows = '{
            '{REQ_ADD, 1, 2, 1, 3, 1'b1, 5, 6, 1'b0},
            '{REQ_SUB, 1, 2, 1, 3, 1'b1, 1, 6, 1'b0},
            '{REQ_MUL, 2, 3, 3, 4, 1'b1, 1, 2, 1'b0},
            '{REQ_DIV, 2, 3, 4, 9, 1'b1, 3, 2, 1'b0},
            '{REQ_ADD, 1, 4, 1, 4, 1'b1, 1, 2, 1'b0},
            '{REQ_SUB, 3, 7, 3, 7, 1'b1, 0, 1, 1'b0},
            '{REQ_ADD, 5, 0, 1, 3, 1'b1, 0, 0, 1'b1},
            '{REQ_SUB, 5, 2, 1, 0, 1'b1, 0, 0, 1'b1},
            '{REQ_MUL, 5, 0, 1, 0, 1'b1, 0, 0, 1'b1},
            '{REQ_DIV, 5, 2, 1, 0, 1'b1, 0, 0, 1'b1},
            '{REQ_DIV, 5, 2, 0, 7, 1'b1, 0, 0, 1'b1},
            '{REQ_MUL, 0, 5, 3, 7, 1'b1, 0, 1, 1'b0},
            '{REQ_MUL, 0, -5, 3, 7, 1'b0, 0, 0, 1'b0},
            '{REQ_DIV, 0, 5, 3, -7, 1'b0, 0, 0, 1'b0},
            '{REQ_ADD, -32768, -32768, -32768, -32768, 1'b0, 0, 0, 1'b0},
            '{REQ_ADD, 32767, -32768, 32767, 32767, 1'b0, 0, 0, 1'b0},
            '{REQ_SUB, -32768, 32767, 32767, -32768, 1'b0, 0, 0, 1'b0},
            '{REQ_MUL, -32768, 32767, -32768, 32767, 1'b0, 0, 0, 1'b0},
            '{REQ_MUL, 32767, -32768, -32768, -1, 1'b0, 0, 0, 1'b0},
            '{REQ_DIV, -32768, 32767, -1, -32768, 1'b0, 0, 0, 1'b0},
            '{REQ_DIV, 32767, -1, -32768, 32767, 1'b0, 0, 0, 1'b0},
            '{REQ_ADD, -1, -1, -1, 1, 1'b0, 0, 0, 1'b0},
            '{REQ_SUB, -7, 6, 5, -4, 1'b0, 0, 0, 1'b0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            b.req_type     = rows[i].op;
            b.a_num        = 16'(rows[i].an);
            b.a_den        = 16'(rows[i].ad);
            b.b_num        = 16'(rows[i].bn);
            b.b_den        = 16'(rows[i].bd);
            answer.res_num = rows[i].rn[NUM_W-1:0];
            answer.res_den = rows[i].rd[DATA_W-1:0];
            answer.error   = rows[i].rerr;
            offer_request(b, rows[i].known, answer);
        end

        // Three phases of random beats: a slow receiver, then a slow sender,
        // then both sides running flat out.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
            recv_stall_pct = (phase == 0) ? 83 : (phase == 1) ? 33 : 0;
            repeat (RANDOM_ITEMS / 3)
            begin
                offer_request(random_request(), 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_fractions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_fractions.size() == 0)
        begin
            $display("rational_arith_unit_test passed");
        end
        else
        begin
            $display("rational_arith_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== rational_arith_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_gcd.sv
rtl/core/rau_div.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arith_unit.sv
dv/rational_arith_unit_test.sv
